[rtl/hnpm_pkg.sv]
// Shared widths, codes and types for the Hamming nearest-pattern memory.
package hnpm_pkg;

   localparam int KEY_W      = 64;
   localparam int RESP_W     = 8;
   localparam int NIDX_W     = 4;
   localparam int DIST_W     = 7;
   localparam int CNT_W      = 4;
   localparam int SUI_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_RANDOM_ENABLE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOTS_IN_USE  = 1'b1;

   localparam logic MODE_RECALL = 1'b0;
   localparam logic MODE_LEARN  = 1'b1;

   localparam logic             RANDOM_ENABLE_RESET = 1'b1;
   localparam logic [SUI_W-1:0] SLOTS_IN_USE_RESET  = 5'd16;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

[rtl/hamming_nearest_pattern_memory_top.sv]
// Hamming nearest-pattern memory: top level with scan control, lanes and slot stores.
// A request is answered on rsp_valid after the scan reads L slots, L = slots_in_use
//   capped at SLOTS, or on a learn that stops at an empty slot or exact match, up to two
//   past it; L may be zero. The block takes one transaction at a time, with
//   one slot read per cycle through the slot RAM's single read port.
// Reset: synchronous; a clearing pass over all NEURONS*SLOTS cells zeroes the slot and
//   worst-distance stores while req_ready stays low; CSR writes are taken throughout.
module hamming_nearest_pattern_memory_top
   import hnpm_pkg::*;
#(
   parameter int NEURONS     = 16,
   parameter int INPUT_BYTES = 8,
   parameter int SLOTS       = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_mode,
   input  logic [NIDX_W-1:0]     req_neuron_index,
   input  logic [KEY_W-1:0]      req_key_pattern,
   input  logic [RESP_W-1:0]     req_teach_response,
   input  logic [RESP_W-1:0]     req_random_byte,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [RESP_W-1:0]     rsp_answer,
   output logic                  rsp_answer_resolved,
   output logic                  rsp_slot_written,
   // configuration port
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int KW    = INPUT_BYTES * 8;
   localparam int CELLS = NEURONS * SLOTS;
   localparam int CB    = CELLS > 1 ? $clog2(CELLS) : 1;
   localparam int NB    = NEURONS > 1 ? $clog2(NEURONS) : 1;
   localparam int SIW   = SLOTS > 1 ? $clog2(SLOTS) : 1;
   localparam int SCW   = $clog2(SLOTS + 1);
   localparam int RW    = 1 + RESP_W + KW;
   localparam logic [CB:0]  NEUR_LIMIT = (CB + 1)'(NEURONS);
   localparam logic [CB-1:0] CLR_LAST  = CB'(CELLS - 1);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic             random_enable_ff;
   logic [SUI_W-1:0] slots_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         random_enable_ff <= RANDOM_ENABLE_RESET;
         slots_in_use_ff  <= SLOTS_IN_USE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RANDOM_ENABLE: random_enable_ff <= csr_wdata[0];
            CSR_SLOTS_IN_USE:  slots_in_use_ff  <= csr_wdata[SUI_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   state_type state_ff, state_in;
   logic [CB-1:0]     clr_ff, clr_in;

   // captured transaction
   logic              mode_ff, mode_in;
   logic [NIDX_W-1:0] neuron_ff, neuron_in;
   logic [KW-1:0]     key_ff, key_in;
   logic [RESP_W-1:0] teach_ff, teach_in;
   logic [RESP_W-1:0] rnd_ff, rnd_in;
   logic [SCW-1:0]    n_ff, n_in;

   // scan issue and pipeline
   logic [SCW-1:0]    rd_idx_ff, rd_idx_in;
   logic              s1_vld_ff, s1_vld_in;
   logic [SIW-1:0]    s1_slot_ff, s1_slot_in;
   logic              s2_vld_ff, s2_vld_in;
   logic [SIW-1:0]    s2_slot_ff, s2_slot_in;
   logic [DIST_W-1:0] s2_dist_ff, s2_dist_in;
   logic              s2_ent_v_ff, s2_ent_v_in;
   logic [RESP_W-1:0] s2_resp_ff, s2_resp_in;

   // accumulators
   logic              seen_ff, seen_in;
   logic              resolved_ff, resolved_in;
   logic              full_ff, full_in;
   logic              stop_ff, stop_in;
   logic [DIST_W-1:0] best_ff, best_in;
   logic [DIST_W-1:0] worst_ff, worst_in;
   logic [SIW-1:0]    target_ff, target_in;
   logic [RESP_W-1:0] best_resp_ff, best_resp_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RESP_W-1:0] rsp_answer_ff, rsp_answer_in;
   logic              rsp_resolved_ff, rsp_resolved_in;
   logic              rsp_written_ff, rsp_written_in;

   // ---------------------------------------------------------------
   // Stores: slot RAM holds {valid, response, pattern}
   // ---------------------------------------------------------------
   logic              slot_we, slot_re;
   logic [CB-1:0]     slot_waddr, slot_raddr;
   logic [RW-1:0]     slot_wdata, slot_rdata;
   logic              worst_we, worst_re;
   logic [NB-1:0]     worst_waddr, worst_raddr;
   logic [DIST_W-1:0] worst_wdata, worst_rdata;

   hnpm_ram #(.WIDTH(RW), .DEPTH(CELLS)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_waddr),
      .wdata (slot_wdata),
      .re    (slot_re),
      .raddr (slot_raddr),
      .rdata (slot_rdata)
   );

   hnpm_ram #(.WIDTH(DIST_W), .DEPTH(NEURONS)) u_worst_ram (
      .clock (clock),
      .we    (worst_we),
      .waddr (worst_waddr),
      .wdata (worst_wdata),
      .re    (worst_re),
      .raddr (worst_raddr),
      .rdata (worst_rdata)
   );

   // ---------------------------------------------------------------
   // Byte lanes and merge: distance of the slot read last cycle
   // ---------------------------------------------------------------
   logic [INPUT_BYTES-1:0][CNT_W-1:0] lane_ones;
   logic [DIST_W-1:0]                 s1_dist;

   for (genvar j = 0; j < INPUT_BYTES; j++) begin : g_lane
      hnpm_lane u_lane (
         .key_byte (key_ff[8*j +: 8]),
         .pat_byte (slot_rdata[8*j +: 8]),
         .ones     (lane_ones[j])
      );
   end

   hnpm_merge #(.LANES(INPUT_BYTES)) u_merge (
      .lane_ones (lane_ones),
      .distance  (s1_dist)
   );

   // ---------------------------------------------------------------
   // Control and datapath next state
   // ---------------------------------------------------------------
   logic          accept;
   logic          issue;
   logic          out_free;
   logic          neuron_ok;
   logic          do_write;
   logic [CB-1:0] neuron_base;

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      mode_in        = mode_ff;
      neuron_in      = neuron_ff;
      key_in         = key_ff;
      teach_in       = teach_ff;
      rnd_in         = rnd_ff;
      n_in           = n_ff;
      rd_idx_in      = rd_idx_ff;
      seen_in        = seen_ff;
      resolved_in    = resolved_ff;
      full_in        = full_ff;
      stop_in        = stop_ff;
      best_in        = best_ff;
      worst_in       = worst_ff;
      target_in      = target_ff;
      best_resp_in   = best_resp_ff;
      rsp_answer_in   = rsp_answer_ff;
      rsp_resolved_in = rsp_resolved_ff;
      rsp_written_in  = rsp_written_ff;

      neuron_base = CB'(neuron_ff) * CB'(SLOTS);
      neuron_ok   = 32'(req_neuron_index) < NEURONS;
      out_free    = !rsp_valid_ff || rsp_ready;
      req_ready   = (state_ff == ST_IDLE);
      accept      = req_valid && req_ready;
      issue       = (state_ff == ST_SCAN) && (rd_idx_ff < n_ff) && !stop_ff;
      do_write    = (mode_ff == MODE_LEARN) && (n_ff != '0) &&
                    (!full_ff || (worst_ff > worst_rdata));

      slot_we     = 1'b0;
      slot_waddr  = neuron_base + CB'(target_ff);
      slot_wdata  = {1'b1, teach_ff, key_ff};
      slot_re     = issue;
      slot_raddr  = neuron_base + CB'(rd_idx_ff[SIW-1:0]);
      worst_we    = 1'b0;
      worst_waddr = NB'(neuron_ff);
      worst_wdata = worst_ff;
      worst_re    = accept;
      worst_raddr = NB'(req_neuron_index);

      // the slot pipeline always advances; entries are dropped once stopped
      s1_vld_in   = issue;
      s1_slot_in  = rd_idx_ff[SIW-1:0];
      s2_vld_in   = s1_vld_ff;
      s2_slot_in  = s1_slot_ff;
      s2_dist_in  = s1_dist;
      s2_ent_v_in = slot_rdata[RW-1];
      s2_resp_in  = slot_rdata[KW +: RESP_W];

      // response register drains when taken
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_CLEAR: begin
            slot_we     = 1'b1;
            slot_waddr  = clr_ff;
            slot_wdata  = '0;
            worst_we    = {1'b0, clr_ff} < NEUR_LIMIT;
            worst_waddr = clr_ff[NB-1:0];
            worst_wdata = '0;
            clr_in      = clr_ff + CB'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               mode_in      = req_mode;
               neuron_in    = req_neuron_index;
               key_in       = req_key_pattern[KW-1:0];
               teach_in     = req_teach_response;
               rnd_in       = req_random_byte;
               if (!neuron_ok) begin
                  n_in = '0;
               end else if (32'(slots_in_use_ff) > SLOTS) begin
                  n_in = SCW'(SLOTS);
               end else begin
                  n_in = SCW'(slots_in_use_ff);
               end
               rd_idx_in    = '0;
               seen_in      = 1'b0;
               resolved_in  = 1'b0;
               full_in      = 1'b1;
               stop_in      = 1'b0;
               best_in      = '0;
               worst_in     = '0;
               target_in    = '0;
               best_resp_in = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + SCW'(1);
            end
            if (s2_vld_ff && !stop_ff) begin
               if (mode_ff == MODE_RECALL) begin
                  if (s2_ent_v_ff) begin
                     if (!seen_ff || (s2_dist_ff < best_ff)) begin
                        seen_in      = 1'b1;
                        best_in      = s2_dist_ff;
                        best_resp_in = s2_resp_ff;
                        resolved_in  = 1'b1;
                     end else if ((s2_dist_ff == best_ff) && resolved_ff &&
                                  (best_resp_ff != s2_resp_ff)) begin
                        resolved_in = 1'b0;
                     end
                  end
               end else begin
                  if (!s2_ent_v_ff) begin
                     // first empty slot takes the pattern
                     target_in = s2_slot_ff;
                     full_in   = 1'b0;
                     stop_in   = 1'b1;
                  end else begin
                     if (!seen_ff || (s2_dist_ff < best_ff)) begin
                        seen_in   = 1'b1;
                        best_in   = s2_dist_ff;
                        target_in = s2_slot_ff;
                     end
                     if (s2_dist_ff > worst_ff) begin
                        worst_in = s2_dist_ff;
                     end
                     if (s2_dist_ff == '0) begin
                        target_in = s2_slot_ff;
                        stop_in   = 1'b1;
                     end
                  end
               end
            end
            if (!issue && !s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (mode_ff == MODE_RECALL) begin
                  rsp_written_in  = 1'b0;
                  rsp_resolved_in = resolved_ff;
                  if (resolved_ff) begin
                     rsp_answer_in = best_resp_ff;
                  end else if (random_enable_ff) begin
                     rsp_answer_in = rnd_ff;
                  end else begin
                     rsp_answer_in = '0;
                  end
               end else begin
                  rsp_answer_in   = '0;
                  rsp_resolved_in = 1'b0;
                  rsp_written_in  = do_write;
                  slot_we         = do_write;
                  worst_we        = do_write && full_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and scan bookkeeping; all loaded before use
   always_ff @(posedge clock) begin
      mode_ff         <= mode_in;
      neuron_ff       <= neuron_in;
      key_ff          <= key_in;
      teach_ff        <= teach_in;
      rnd_ff          <= rnd_in;
      n_ff            <= n_in;
      rd_idx_ff       <= rd_idx_in;
      s1_slot_ff      <= s1_slot_in;
      s2_slot_ff      <= s2_slot_in;
      s2_dist_ff      <= s2_dist_in;
      s2_ent_v_ff     <= s2_ent_v_in;
      s2_resp_ff      <= s2_resp_in;
      seen_ff         <= seen_in;
      resolved_ff     <= resolved_in;
      full_ff         <= full_in;
      stop_ff         <= stop_in;
      best_ff         <= best_in;
      worst_ff        <= worst_in;
      target_ff       <= target_in;
      best_resp_ff    <= best_resp_in;
      rsp_answer_ff   <= rsp_answer_in;
      rsp_resolved_ff <= rsp_resolved_in;
      rsp_written_ff  <= rsp_written_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_answer          = rsp_answer_ff;
   assign rsp_answer_resolved = rsp_resolved_ff;
   assign rsp_slot_written    = rsp_written_ff;

endmodule

[rtl/hnpm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module hnpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/hnpm_lane.sv]
// One byte lane: count of differing bits between a key byte and a stored byte.
module hnpm_lane
   import hnpm_pkg::*;
(
   input  logic [7:0]       key_byte,
   input  logic [7:0]       pat_byte,
   output logic [CNT_W-1:0] ones
);

   logic [7:0] diff;

   always_comb begin
      diff = key_byte ^ pat_byte;
      ones = '0;
      for (int b = 0; b < 8; b++) begin
         ones = ones + CNT_W'(diff[b]);
      end
   end

endmodule

[rtl/hnpm_merge.sv]
// Merge stage: add the per-lane bit counts into one Hamming distance.
module hnpm_merge
   import hnpm_pkg::*;
#(
   parameter int LANES = 8
) (
   input  logic [LANES-1:0][CNT_W-1:0] lane_ones,
   output logic [DIST_W-1:0]           distance
);

   always_comb begin
      distance = '0;
      for (int j = 0; j < LANES; j++) begin
         distance = distance + DIST_W'(lane_ones[j]);
      end
   end

endmodule

[rtl/hnpm_checker.sv]
// Port-level checker for the Hamming nearest-pattern memory, bound to the top level.
module hnpm_checker
   import hnpm_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [RESP_W-1:0] rsp_answer,
   input logic              rsp_answer_resolved,
   input logic              rsp_slot_written
);

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_answer) &&
         $stable(rsp_answer_resolved) && $stable(rsp_slot_written))
      else $error("stalled response changed");

   // a response is never both resolved (recall) and slot-written (learn)
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_answer_resolved && rsp_slot_written))
      else $error("response both resolved and written");

   // learn responses that wrote a slot carry a zero answer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slot_written |-> rsp_answer == '0)
      else $error("learn response with nonzero answer");

   // one transaction at a time: no acceptance on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("back-to-back request acceptance");

   // nothing leaves the block straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

endmodule

bind hamming_nearest_pattern_memory_top hnpm_checker u_hnpm_checker (.*);
